@@ rtl/tia_pkg.sv @@
package tia_pkg;

  localparam int unsigned DivStages = 64;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0,
    OP_SUB = 5'd1,
    OP_MUL = 5'd2,
    OP_DIV = 5'd3,
    OP_MOD = 5'd4,
    OP_AND = 5'd5,
    OP_OR  = 5'd6,
    OP_XOR = 5'd7,
    OP_EQ  = 5'd8,
    OP_NE  = 5'd9,
    OP_LT  = 5'd10,
    OP_LE  = 5'd11,
    OP_GT  = 5'd12,
    OP_GE  = 5'd13,
    OP_SHL = 5'd14,
    OP_SHR = 5'd15,
    OP_INV = 5'd16,
    OP_NEG = 5'd17,
    OP_INC = 5'd18,
    OP_DEC = 5'd19
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SIGN_MIX = 3'd1,
    ST_DIV_ZERO = 3'd2,
    ST_SHIFT    = 3'd3,
    ST_NEG_UNS  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SEL_ALU = 2'd0,
    SEL_MUL = 2'd1,
    SEL_DIV = 2'd2,
    SEL_MOD = 2'd3
  } sel_e;

  typedef struct packed {
    logic [63:0] res;
    status_e     status;
    logic [1:0]  rw;
    logic        rs;
    sel_e        sel;
    logic        neg_q;
    logic        neg_r;
  } side_t;

  function automatic logic [63:0] extend(logic [63:0] v, logic [1:0] w, logic s);
    logic [63:0] r;
    unique case (w)
      2'd0: r = {{56{s & v[7]}}, v[7:0]};
      2'd1: r = {{48{s & v[15]}}, v[15:0]};
      2'd2: r = {{32{s & v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/typed_integer_alu.sv @@
// channel  | ports                                        | handshake
// request  | mode_i a_value_i a_width_i a_signed_i         | start && !busy
//          | b_value_i b_width_i b_signed_i                |
// result   | result_value_o result_width_o result_signed_o | result_valid_o, one cycle
//          | status_o                                      |
// One request per cycle; the result passes the stage 1 registers, the divider stages and the output register.
// Latency is set by the 64-stage restoring divider, one quotient bit per stage.
// Reset clears the valid bits only; busy is always low.
// The receiver cannot stall, so the pipeline never holds.
module typed_integer_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  mode_i,
  input  logic [63:0] a_value_i,
  input  logic [1:0]  a_width_i,
  input  logic        a_signed_i,
  input  logic [63:0] b_value_i,
  input  logic [1:0]  b_width_i,
  input  logic        b_signed_i,
  output logic        result_valid_o,
  output logic [63:0] result_value_o,
  output logic [1:0]  result_width_o,
  output logic        result_signed_o,
  output logic [2:0]  status_o
);
  import tia_pkg::*;

  // stage 1: extended operands
  logic        v1_q;
  logic [4:0]  mode_q;
  logic [63:0] a_q, b_q;
  logic [1:0]  aw_q, bw_q;
  logic        as_q, bs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_i;
    a_q    <= extend(a_value_i, a_width_i, a_signed_i);
    b_q    <= extend(b_value_i, b_width_i, b_signed_i);
    aw_q   <= a_width_i;
    bw_q   <= b_width_i;
    as_q   <= a_signed_i;
    bs_q   <= b_signed_i;
  end

  // stage 2: alu ops, partial products, divider setup
  side_t       s2_d;
  logic [63:0] ma_d, mb_d, ka, kb;
  logic [63:0] shl_v, shr_v;
  logic [6:0]  bits;
  logic [5:0]  amt;
  logic        big;

  always_comb begin
    ka    = as_q ? {~a_q[63], a_q[62:0]} : a_q;
    kb    = as_q ? {~b_q[63], b_q[62:0]} : b_q;
    bits  = 7'd8 << aw_q;
    big   = (b_q[7:0] >= {1'b0, bits});
    amt   = b_q[5:0];
    shl_v = big ? 64'd0 : (a_q << amt);
    if (as_q && a_q[63]) begin
      shr_v = big ? '1 : ~((~a_q) >> amt);
    end else begin
      shr_v = big ? 64'd0 : (a_q >> amt);
    end
    ma_d  = (as_q && a_q[63]) ? 64'd0 - a_q : a_q;
    mb_d  = (as_q && b_q[63]) ? 64'd0 - b_q : b_q;

    s2_d        = '0;
    s2_d.rw     = aw_q;
    s2_d.rs     = as_q;
    s2_d.status = ST_OK;
    s2_d.sel    = SEL_ALU;
    s2_d.neg_q  = as_q && (a_q[63] != b_q[63]);
    s2_d.neg_r  = as_q && a_q[63];
    if (mode_q <= OP_GE) begin
      s2_d.rw = (aw_q > bw_q) ? aw_q : bw_q;
      if (as_q != bs_q) begin
        s2_d.status = ST_SIGN_MIX;
      end else begin
        unique case (mode_q)
          OP_ADD: s2_d.res = a_q + b_q;
          OP_SUB: s2_d.res = a_q - b_q;
          OP_MUL: s2_d.sel = SEL_MUL;
          OP_DIV, OP_MOD: begin
            s2_d.sel = (mode_q == OP_DIV) ? SEL_DIV : SEL_MOD;
            if (b_q == 64'd0) begin
              s2_d.status = ST_DIV_ZERO;
            end
          end
          OP_AND: s2_d.res = a_q & b_q;
          OP_OR:  s2_d.res = a_q | b_q;
          OP_XOR: s2_d.res = a_q ^ b_q;
          OP_EQ:  s2_d.res = {63'd0, ka == kb};
          OP_NE:  s2_d.res = {63'd0, ka != kb};
          OP_LT:  s2_d.res = {63'd0, ka < kb};
          OP_LE:  s2_d.res = {63'd0, ka <= kb};
          OP_GT:  s2_d.res = {63'd0, ka > kb};
          default: s2_d.res = {63'd0, ka >= kb};
        endcase
      end
    end else begin
      unique case (mode_q)
        OP_SHL, OP_SHR: begin
          if ((bs_q && b_q[63]) || (b_q > 64'd255)) begin
            s2_d.status = ST_SHIFT;
          end else begin
            s2_d.res = (mode_q == OP_SHL) ? shl_v : shr_v;
          end
        end
        OP_INV: s2_d.res = ~a_q;
        OP_NEG: begin
          if (!as_q) begin
            s2_d.status = ST_NEG_UNS;
          end else begin
            s2_d.res = 64'd0 - a_q;
          end
        end
        OP_INC: s2_d.res = a_q + 64'd1;
        OP_DEC: s2_d.res = a_q - 64'd1;
        default: s2_d.res = 64'd0;
      endcase
    end
  end

  // divider stages, index 0 is loaded from stage 2
  logic [63:0] rem_q [DivStages+1];
  logic [63:0] quo_q [DivStages+1];
  logic [63:0] den_q [DivStages+1];
  side_t       side_q [DivStages+1];
  logic        vld_q [DivStages+1];
  logic [63:0] rem_d [DivStages+1];
  logic [63:0] quo_d [DivStages+1];
  side_t       side_d [DivStages+1];
  logic [63:0] mul_ll_q;
  logic [31:0] mul_lh_q, mul_hl_q;
  logic [31:0] mul_cross;
  logic [64:0] sh, diff;

  assign mul_cross = mul_lh_q + mul_hl_q;

  always_comb begin
    rem_d[0]  = 64'd0;
    quo_d[0]  = ma_d;
    side_d[0] = s2_d;
    sh        = '0;
    diff      = '0;
    for (int k = 1; k <= DivStages; k++) begin
      sh        = {rem_q[k-1], quo_q[k-1][63]};
      diff      = sh - {1'b0, den_q[k-1]};
      rem_d[k]  = diff[64] ? sh[63:0] : diff[63:0];
      quo_d[k]  = {quo_q[k-1][62:0], ~diff[64]};
      side_d[k] = side_q[k-1];
    end
    if (side_q[0].sel == SEL_MUL) begin
      side_d[1].res = mul_ll_q + {mul_cross, 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivStages; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= v1_q;
      for (int k = 1; k <= DivStages; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= rem_d[0];
    quo_q[0]  <= quo_d[0];
    den_q[0]  <= mb_d;
    side_q[0] <= side_d[0];
    mul_ll_q  <= a_q[31:0] * b_q[31:0];
    mul_lh_q  <= a_q[31:0] * b_q[63:32];
    mul_hl_q  <= a_q[63:32] * b_q[31:0];
    for (int k = 1; k <= DivStages; k++) begin
      rem_q[k]  <= rem_d[k];
      quo_q[k]  <= quo_d[k];
      den_q[k]  <= den_q[k-1];
      side_q[k] <= side_d[k];
    end
  end

  // output stage
  side_t       fin;
  logic [63:0] r_sel;
  logic        out_v_q;
  logic [63:0] out_val_q;
  logic [1:0]  out_w_q;
  logic        out_s_q;
  logic [2:0]  out_st_q;

  assign fin = side_q[DivStages];

  always_comb begin
    unique case (fin.sel)
      SEL_DIV: r_sel = fin.neg_q ? 64'd0 - quo_q[DivStages] : quo_q[DivStages];
      SEL_MOD: r_sel = fin.neg_r ? 64'd0 - rem_q[DivStages] : rem_q[DivStages];
      default: r_sel = fin.res;
    endcase
    if (fin.status != ST_OK) begin
      r_sel = 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= extend(r_sel, fin.rw, fin.rs);
    out_w_q   <= fin.rw;
    out_s_q   <= fin.rs;
    out_st_q  <= fin.status;
  end

  assign busy            = 1'b0;
  assign result_valid_o  = out_v_q;
  assign result_value_o  = out_val_q;
  assign result_width_o  = out_w_q;
  assign result_signed_o = out_s_q;
  assign status_o        = out_st_q;

endmodule

@@ rtl/tia_checker.sv @@
module tia_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [63:0] result_value_o,
  input logic [2:0]  status_o
);
  import tia_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##67 result_valid_o)
    else $error("result missing");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, 67))
    else $error("result without request");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_OK) |-> result_value_o == 64'd0)
    else $error("nonzero result with error status");

endmodule

bind typed_integer_alu tia_checker u_tia_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_value_o (result_value_o),
  .status_o       (status_o)
);

@@ bench/typed_integer_alu_tb.sv @@
`timescale 1ns / 100ps

module typed_integer_alu_tb;
  import tia_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  width;
    logic        sgn;
    status_e     status;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function automatic logic [63:0] wmask(logic [1:0] w);
      logic [63:0] m;
      case (w)
        2'd0: m = 64'hff;
        2'd1: m = 64'hffff;
        2'd2: m = 64'hffff_ffff;
        default: m = '1;
      endcase
      return m;
    endfunction

    function automatic logic [63:0] widen(logic [63:0] v, logic [1:0] w, logic s);
      logic [63:0] m;
      int unsigned top;
      m = wmask(w);
      top = (8 << w) - 1;
      v = v & m;
      if (s && w != 2'd3 && v[top]) v = v | ~m;
      return v;
    endfunction

    function automatic alu_result_t compute(logic [4:0] op, logic [63:0] av,
                                             logic [1:0] aw, logic as,
                                             logic [63:0] bv, logic [1:0] bw,
                                             logic bs);
      alu_result_t q;
      logic [63:0] a, b, r, ka, kb, ma, mb, sflip;
      int unsigned amt, bits;
      a = widen(av, aw, as);
      b = widen(bv, bw, bs);
      q.width = aw;
      q.sgn = as;
      q.status = ST_OK;
      r = '0;
      sflip = 64'h8000_0000_0000_0000;
      if (op <= OP_GE) begin
        q.width = (aw > bw) ? aw : bw;
        if (as != bs) begin
          q.status = ST_SIGN_MIX;
        end else begin
          ka = as ? a ^ sflip : a;
          kb = as ? b ^ sflip : b;
          case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV, OP_MOD: begin
              if ((b & wmask(q.width)) == 0) begin
                q.status = ST_DIV_ZERO;
              end else if (!as) begin
                r = (op == OP_DIV) ? a / b : a % b;
              end else begin
                ma = a[63] ? -a : a;
                mb = b[63] ? -b : b;
                if (op == OP_DIV) begin
                  r = ma / mb;
                  if (a[63] != b[63]) r = -r;
                end else begin
                  r = ma % mb;
                  if (a[63]) r = -r;
                end
              end
            end
            OP_AND: r = a & b;
            OP_OR:  r = a | b;
            OP_XOR: r = a ^ b;
            OP_EQ:  r = {63'd0, ka == kb};
            OP_NE:  r = {63'd0, ka != kb};
            OP_LT:  r = {63'd0, ka < kb};
            OP_LE:  r = {63'd0, ka <= kb};
            OP_GT:  r = {63'd0, ka > kb};
            default: r = {63'd0, ka >= kb};
          endcase
        end
      end else if (op == OP_SHL || op == OP_SHR) begin
        if ((bs && b[63]) || b > 64'd255) begin
          q.status = ST_SHIFT;
        end else begin
          amt = 32'(b[7:0]);
          bits = 8 << aw;
          if (op == OP_SHL) r = (amt >= bits) ? '0 : a << amt;
          else if (as && a[63]) r = (amt >= bits) ? '1 : ~((~a) >> amt);
          else r = (amt >= bits) ? '0 : a >> amt;
        end
      end else if (op == OP_INV) begin
        r = ~a;
      end else if (op == OP_NEG) begin
        if (!as) q.status = ST_NEG_UNS;
        else r = -a;
      end else if (op == OP_INC) begin
        r = a + 1;
      end else if (op == OP_DEC) begin
        r = a - 1;
      end
      if (q.status != ST_OK) r = '0;
      q.value = widen(r, q.width, q.sgn);
      return q;
    endfunction

    function void note_request(logic [4:0] op, logic [63:0] av, logic [1:0] aw,
                               logic as, logic [63:0] bv, logic [1:0] bw, logic bs);
      pending.push_back(compute(op, av, aw, as, bv, bw, bs));
    endfunction

    function void check_result(logic [63:0] v, logic [1:0] w, logic s, logic [2:0] st);
      alu_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h", $time, v);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (v !== e.value) begin
        $display("%0t: value exp=%h act=%h", $time, e.value, v);
        errors++;
      end
      if (w !== e.width) begin
        $display("%0t: width exp=%0d act=%0d", $time, e.width, w);
        errors++;
      end
      if (s !== e.sgn) begin
        $display("%0t: signed exp=%0d act=%0d", $time, e.sgn, s);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status exp=%0d act=%0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [4:0]  mode_i = '0;
  logic [63:0] a_value_i = '0;
  logic [1:0]  a_width_i = '0;
  logic        a_signed_i = 1'b0;
  logic [63:0] b_value_i = '0;
  logic [1:0]  b_width_i = '0;
  logic        b_signed_i = 1'b0;
  logic        result_valid_o;
  logic [63:0] result_value_o;
  logic [1:0]  result_width_o;
  logic        result_signed_o;
  logic [2:0]  status_o;

  alu_scoreboard sb = new();
  int unsigned cycles;
  int unsigned sent;
  logic        no_gaps;

  typed_integer_alu dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("typed_integer_alu test failed");
      $finish;
    end
    if (rst_ni && result_valid_o)
      sb.check_result(result_value_o, result_width_o, result_signed_o, status_o);
    if (rst_ni && start && !busy) begin
      sb.note_request(mode_i, a_value_i, a_width_i, a_signed_i,
                      b_value_i, b_width_i, b_signed_i);
      sent++;
    end
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return {$urandom, $urandom} >> $urandom_range(0, 63);
      4: return 64'h0000_0000_0000_0080 << (8 * $urandom_range(0, 7));
      5: return 64'h7f << (8 * $urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_request(logic [4:0] op, logic [63:0] av, logic [1:0] aw,
                              logic as, logic [63:0] bv, logic [1:0] bw, logic bs);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 12) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start <= 1'b1;
    mode_i <= op;
    a_value_i <= av;
    a_width_i <= aw;
    a_signed_i <= as;
    b_value_i <= bv;
    b_width_i <= bw;
    b_signed_i <= bs;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [1:0] w;
    logic s;
    no_gaps = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(OP_ADD, '1, 2'd3, 1'b0, 64'd1, 2'd0, 1'b0);
    send_request(OP_ADD, 64'hff, 2'd0, 1'b1, 64'h7fff, 2'd1, 1'b1);
    send_request(OP_SUB, 64'd5, 2'd0, 1'b1, 64'd3, 2'd0, 1'b0);
    send_request(OP_MUL, 64'hffff_ffff, 2'd2, 1'b0, 64'hffff_ffff, 2'd2, 1'b0);
    send_request(OP_DIV, 64'h80, 2'd0, 1'b1, 64'hff, 2'd0, 1'b1);
    send_request(OP_DIV, 64'h8000_0000_0000_0000, 2'd3, 1'b1, '1, 2'd3, 1'b1);
    send_request(OP_MOD, 64'h8000_0000_0000_0000, 2'd3, 1'b1, '1, 2'd3, 1'b1);
    send_request(OP_DIV, 64'd7, 2'd1, 1'b0, 64'h100, 2'd0, 1'b0);
    send_request(OP_MOD, 64'hf9, 2'd0, 1'b1, 64'd2, 2'd0, 1'b1);
    send_request(OP_MOD, 64'd9, 2'd2, 1'b0, '0, 2'd3, 1'b0);
    send_request(OP_AND, '1, 2'd3, 1'b0, 64'hf0f0, 2'd1, 1'b0);
    send_request(OP_OR, 64'h1, 2'd0, 1'b1, 64'h80, 2'd0, 1'b1);
    send_request(OP_XOR, '1, 2'd1, 1'b1, 64'h55, 2'd2, 1'b1);
    for (int op = OP_EQ; op <= OP_GE; op++)
      send_request(op[4:0], 64'hff, 2'd0, 1'b1, 64'd1, 2'd1, 1'b1);
    send_request(OP_SHL, 64'h1, 2'd3, 1'b0, 64'd63, 2'd0, 1'b0);
    send_request(OP_SHR, 64'h80, 2'd0, 1'b1, 64'd200, 2'd0, 1'b0);
    send_request(OP_SHR, 64'h80, 2'd0, 1'b1, 64'hff, 2'd0, 1'b1);
    send_request(OP_SHL, 64'd1, 2'd0, 1'b0, 64'd256, 2'd1, 1'b0);
    send_request(OP_INV, 64'h0, 2'd1, 1'b1, '0, 2'd0, 1'b0);
    send_request(OP_NEG, 64'h80, 2'd0, 1'b1, '0, 2'd0, 1'b0);
    send_request(OP_NEG, 64'd3, 2'd2, 1'b0, '0, 2'd0, 1'b0);
    send_request(OP_INC, 64'hffff, 2'd1, 1'b0, '0, 2'd0, 1'b0);
    send_request(OP_DEC, 64'h0, 2'd2, 1'b1, '0, 2'd0, 1'b0);
    send_request(5'd31, '1, 2'd2, 1'b1, '1, 2'd3, 1'b1);

    drain();
    @(negedge clk_i);

    for (int i = 0; i < 700; i++) begin
      no_gaps = (i >= 300 && i < 420);
      if (i == 500) drain();
      w = 2'($urandom_range(0, 3));
      s = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 8)
        send_request(5'(($urandom_range(0, 99) < 3) ? $urandom_range(20, 31)
                                                    : $urandom_range(0, 19)),
                     pick_value(), w, s, ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 300))
                     : pick_value(), 2'($urandom_range(0, 3)),
                     ($urandom_range(0, 9) == 0) ? ~s : s);
      else
        send_request(5'($urandom_range(0, 31)), pick_value(), w, s, pick_value(),
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
    drain();
    repeat (80) @(negedge clk_i);
    $display("Sent %0d requests over all ops, widths and signedness; checked %0d results.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("typed_integer_alu test passed");
    else
      $display("typed_integer_alu test failed");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/tia_pkg.sv
rtl/typed_integer_alu.sv
rtl/tia_checker.sv
bench/typed_integer_alu_tb.sv
